[sv/rpr_pkg.sv]
// Shared types and register indexes for the relative pose retarget block.
`timescale 1ns / 1ps

package rpr_pkg;

  typedef logic signed [31:0] word_t;
  typedef logic signed [63:0] dword_t;

  localparam int unsigned CFG_IDX_W = 3;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_POS_X  = 3'd0,
    REG_POS_Y  = 3'd1,
    REG_POS_Z  = 3'd2,
    REG_QUAT_X = 3'd3,
    REG_QUAT_Y = 3'd4,
    REG_QUAT_Z = 3'd5,
    REG_QUAT_W = 3'd6
  } cfg_idx_e;

  // Block-scale limit: every quaternion component is kept within +-2^30.
  localparam dword_t QLIM = 64'sd1073741824;

endpackage

[sv/relative_pose_retarget.sv]
// Relative pose retarget: anchor latch, position offset, quaternion map and normalize.
// Throughput: one request per cycle unless out_stall_i holds the pipeline; the
// 32-step square root and the QUAT_FRAC_BITS + 1 step divider are fully pipelined,
// one stage per step.
// Reset: no anchor, reference pose zero with identity orientation, pipeline empty.
// The first request after reset becomes the anchor and yields no result.
`timescale 1ns / 1ps

module relative_pose_retarget #(
  parameter int unsigned QUAT_FRAC_BITS = 30
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic [rpr_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [31:0]                    cfg_data_i,
  input  logic                           in_valid_i,
  output logic                           in_stall_o,
  input  rpr_pkg::word_t                 in_pos_x_i,
  input  rpr_pkg::word_t                 in_pos_y_i,
  input  rpr_pkg::word_t                 in_pos_z_i,
  input  rpr_pkg::word_t                 in_quat_x_i,
  input  rpr_pkg::word_t                 in_quat_y_i,
  input  rpr_pkg::word_t                 in_quat_z_i,
  input  rpr_pkg::word_t                 in_quat_w_i,
  output logic                           out_valid_o,
  input  logic                           out_stall_i,
  output rpr_pkg::word_t                 out_pos_x_o,
  output rpr_pkg::word_t                 out_pos_y_o,
  output rpr_pkg::word_t                 out_pos_z_o,
  output rpr_pkg::word_t                 out_quat_x_o,
  output rpr_pkg::word_t                 out_quat_y_o,
  output rpr_pkg::word_t                 out_quat_z_o,
  output rpr_pkg::word_t                 out_quat_w_o
);
  import rpr_pkg::*;

  localparam int unsigned F         = QUAT_FRAC_BITS;
  localparam int unsigned ST_SAT    = 1;
  localparam int unsigned ST_SQR    = 19;
  localparam int unsigned ST_N2     = 21;
  localparam int unsigned SQ_STEPS  = 32;
  localparam int unsigned ST_SQ     = 22;
  localparam int unsigned ST_NUM    = ST_SQ + SQ_STEPS;
  localparam int unsigned ST_DIV    = ST_NUM + 1;
  localparam int unsigned DIV_STEPS = F + 1;
  localparam int unsigned ST_OUT    = ST_DIV + DIV_STEPS;
  localparam int unsigned NS        = ST_OUT + 1;
  localparam word_t       QONE      = word_t'(32'd1 << F);

  typedef struct packed {
    logic [2:0][31:0] pos;
    logic [3:0][30:0] mag;
    logic [3:0]       neg;
  } side_t;

  // Smallest right shift that brings all four components into range.
  function automatic logic [5:0] rs_of(input dword_t v);
    logic [5:0] k;
    dword_t     sh;
    k = 6'd33;
    for (int i = 33; i >= 0; i--) begin
      sh = v >>> i;
      if (sh <= QLIM && sh >= -QLIM) k = 6'(i);
    end
    return k;
  endfunction

  function automatic logic [5:0] rs4(input dword_t a, input dword_t b,
                                     input dword_t c, input dword_t d);
    logic [5:0] m, x;
    m = rs_of(a);
    x = rs_of(b); if (x > m) m = x;
    x = rs_of(c); if (x > m) m = x;
    x = rs_of(d); if (x > m) m = x;
    return m;
  endfunction

  // Largest left shift that keeps a component in range; zero allows any.
  function automatic logic [4:0] ls_of(input word_t v);
    logic [4:0]  k;
    logic [63:0] m;
    m = v[31] ? 64'(-dword_t'(v)) : 64'(dword_t'(v));
    k = 5'd31;
    if (m != 64'd0) begin
      k = 5'd0;
      for (int i = 0; i < 31; i++) begin
        if ((m << i) <= 64'd1073741824) k = 5'(i);
      end
    end
    return k;
  endfunction

  function automatic logic [4:0] ls4(input word_t a, input word_t b,
                                     input word_t c, input word_t d);
    logic [4:0] m, x;
    m = ls_of(a);
    x = ls_of(b); if (x < m) m = x;
    x = ls_of(c); if (x < m) m = x;
    x = ls_of(d); if (x < m) m = x;
    return m;
  endfunction

  function automatic logic [31:0] sat_pos(input logic signed [33:0] s);
    logic [31:0] r;
    if (s > 34'sd2147483647) r = 32'h7FFF_FFFF;
    else if (s < -34'sd2147483648) r = 32'h8000_0000;
    else r = s[31:0];
    return r;
  endfunction

  function automatic logic [127:0] sqrt_step(input logic [63:0] n, input logic [63:0] r,
                                             input int unsigned k);
    logic [63:0] b, t;
    b = 64'd1 << (62 - 2 * k);
    t = r + b;
    if (n >= t) return {n - t, (r >> 1) + b};
    else return {n, r >> 1};
  endfunction

  function automatic logic [64:0] div_step(input logic [63:0] rem, input logic [31:0] d,
                                           input int unsigned sh);
    logic [63:0] t;
    t = 64'(d) << sh;
    if (rem >= t) return {1'b1, rem - t};
    else return {1'b0, rem};
  endfunction

  // ---------------- configuration and anchor ----------------
  word_t ref_pos_q  [3];
  word_t ref_quat_q [4];
  word_t anc_pos_q  [3];
  word_t anc_q      [4];
  logic  anchor_valid_q;

  logic [NS-1:0] v_q;
  logic [NS-1:0] rdy;
  logic          in_acc;

  assign in_acc     = in_valid_i && rdy[0];
  assign in_stall_o = !rdy[0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < 3; i++) ref_pos_q[i] <= '0;
      for (int i = 0; i < 3; i++) ref_quat_q[i] <= '0;
      ref_quat_q[3] <= QONE;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        REG_POS_X:  ref_pos_q[0]  <= cfg_data_i;
        REG_POS_Y:  ref_pos_q[1]  <= cfg_data_i;
        REG_POS_Z:  ref_pos_q[2]  <= cfg_data_i;
        REG_QUAT_X: ref_quat_q[0] <= cfg_data_i;
        REG_QUAT_Y: ref_quat_q[1] <= cfg_data_i;
        REG_QUAT_Z: ref_quat_q[2] <= cfg_data_i;
        REG_QUAT_W: ref_quat_q[3] <= cfg_data_i;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      anchor_valid_q <= 1'b0;
    end else if (in_acc) begin
      anchor_valid_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc && !anchor_valid_q) begin
      anc_pos_q[0] <= in_pos_x_i;
      anc_pos_q[1] <= in_pos_y_i;
      anc_pos_q[2] <= in_pos_z_i;
      anc_q[0]     <= in_quat_x_i;
      anc_q[1]     <= in_quat_y_i;
      anc_q[2]     <= in_quat_z_i;
      anc_q[3]     <= in_quat_w_i;
    end
  end

  // ---------------- pipeline control ----------------
  // A stage loads when it is empty or the stage after it loads.
  assign rdy[NS-1] = !v_q[NS-1] || !out_stall_i;
  for (genvar k = 0; k < NS - 1; k++) begin : g_rdy
    assign rdy[k] = !v_q[k] || rdy[k+1];
  end

  // Drop the anchor request at the door.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else begin
      if (rdy[0]) v_q[0] <= in_valid_i && anchor_valid_q;
      for (int k = 1; k < NS; k++) begin
        if (rdy[k]) v_q[k] <= v_q[k-1];
      end
    end
  end

  // ---------------- reference orientation scaling ----------------
  // Free running; user changes reference only while the block is empty (unchecked).
  logic [5:0] grs_q;
  logic [4:0] gls_q;
  word_t      g1_q [4];
  word_t      g2_q [4];
  word_t      g3_q [4];
  word_t      g4_q [4];

  always_ff @(posedge clk_i) begin
    grs_q <= rs4(dword_t'(ref_quat_q[0]), dword_t'(ref_quat_q[1]),
                 dword_t'(ref_quat_q[2]), dword_t'(ref_quat_q[3]));
    g1_q  <= ref_quat_q;
    for (int i = 0; i < 4; i++) g2_q[i] <= g1_q[i] >>> grs_q;
    gls_q <= ls4(g2_q[0], g2_q[1], g2_q[2], g2_q[3]);
    g3_q  <= g2_q;
    for (int i = 0; i < 4; i++) g4_q[i] <= g3_q[i] <<< gls_q;
  end

  // ---------------- side data: position and norm bookkeeping ----------------
  side_t side_q [NS];
  side_t side_d [NS];

  word_t t18_q [4];
  logic [63:0] n2_q;

  always_comb begin
    side_d[0]        = '0;
    side_d[0].pos[0] = in_pos_x_i;
    side_d[0].pos[1] = in_pos_y_i;
    side_d[0].pos[2] = in_pos_z_i;
    for (int k = 1; k < NS; k++) side_d[k] = side_q[k-1];
    for (int i = 0; i < 3; i++) begin
      side_d[ST_SAT].pos[i] = sat_pos(34'(ref_pos_q[i]) + 34'($signed(side_q[0].pos[i]))
                                      - 34'(anc_pos_q[i]));
    end
    for (int i = 0; i < 4; i++) begin
      side_d[ST_SQR].neg[i] = t18_q[i][31];
      side_d[ST_SQR].mag[i] = t18_q[i][31] ? 31'(-t18_q[i]) : 31'(t18_q[i]);
    end
  end

  always_ff @(posedge clk_i) begin
    for (int k = 0; k < NS; k++) begin
      if (rdy[k]) side_q[k] <= side_d[k];
    end
  end

  // ---------------- input and anchor block scaling ----------------
  word_t      qin_q [4];
  logic [5:0] rsq_q, rsa_q;
  logic [4:0] lsq_q, lsa_q;
  word_t      q1_q [4], a1_q [4];
  word_t      q2_q [4], a2_q [4];
  word_t      q3_q [4], a3_q [4];
  word_t      q4_q [4], a4_q [4];

  always_ff @(posedge clk_i) begin
    if (rdy[0]) begin
      qin_q[0] <= in_quat_x_i;
      qin_q[1] <= in_quat_y_i;
      qin_q[2] <= in_quat_z_i;
      qin_q[3] <= in_quat_w_i;
    end
    if (rdy[1]) begin
      q1_q  <= qin_q;
      a1_q  <= anc_q;
      rsq_q <= rs4(dword_t'(qin_q[0]), dword_t'(qin_q[1]),
                   dword_t'(qin_q[2]), dword_t'(qin_q[3]));
      rsa_q <= rs4(dword_t'(anc_q[0]), dword_t'(anc_q[1]),
                   dword_t'(anc_q[2]), dword_t'(anc_q[3]));
    end
    if (rdy[2]) begin
      for (int i = 0; i < 4; i++) begin
        q2_q[i] <= q1_q[i] >>> rsq_q;
        a2_q[i] <= a1_q[i] >>> rsa_q;
      end
    end
    if (rdy[3]) begin
      q3_q  <= q2_q;
      a3_q  <= a2_q;
      lsq_q <= ls4(q2_q[0], q2_q[1], q2_q[2], q2_q[3]);
      lsa_q <= ls4(a2_q[0], a2_q[1], a2_q[2], a2_q[3]);
    end
    // Conjugate the anchor on the way out.
    if (rdy[4]) begin
      for (int i = 0; i < 4; i++) begin
        q4_q[i] <= q3_q[i] <<< lsq_q;
        a4_q[i] <= (i < 3) ? -(a3_q[i] <<< lsa_q) : (a3_q[i] <<< lsa_q);
      end
    end
  end

  // ---------------- r = in * conj(anchor) ----------------
  dword_t pa_q [4][4];
  dword_t ha_q [4][2];
  dword_t r_q  [4];

  always_ff @(posedge clk_i) begin
    if (rdy[5]) begin
      for (int i = 0; i < 4; i++) begin
        for (int j = 0; j < 4; j++) pa_q[i][j] <= q4_q[i] * a4_q[j];
      end
    end
    if (rdy[6]) begin
      ha_q[0][0] <= pa_q[3][0] + pa_q[0][3];
      ha_q[0][1] <= pa_q[1][2] - pa_q[2][1];
      ha_q[1][0] <= pa_q[3][1] - pa_q[0][2];
      ha_q[1][1] <= pa_q[1][3] + pa_q[2][0];
      ha_q[2][0] <= pa_q[3][2] + pa_q[0][1];
      ha_q[2][1] <= pa_q[2][3] - pa_q[1][0];
      ha_q[3][0] <= pa_q[3][3] - pa_q[0][0];
      ha_q[3][1] <= -(pa_q[1][1] + pa_q[2][2]);
    end
    if (rdy[7]) begin
      for (int i = 0; i < 4; i++) r_q[i] <= ha_q[i][0] + ha_q[i][1];
    end
  end

  // ---------------- block scale r ----------------
  logic [5:0] rsr_q;
  logic [4:0] lsr_q;
  dword_t     r8_q [4];
  word_t      r9_q [4], r10_q [4], r11_q [4];

  always_ff @(posedge clk_i) begin
    if (rdy[8]) begin
      r8_q  <= r_q;
      rsr_q <= rs4(r_q[0], r_q[1], r_q[2], r_q[3]);
    end
    if (rdy[9]) begin
      for (int i = 0; i < 4; i++) r9_q[i] <= 32'(r8_q[i] >>> rsr_q);
    end
    if (rdy[10]) begin
      r10_q <= r9_q;
      lsr_q <= ls4(r9_q[0], r9_q[1], r9_q[2], r9_q[3]);
    end
    if (rdy[11]) begin
      for (int i = 0; i < 4; i++) r11_q[i] <= r10_q[i] <<< lsr_q;
    end
  end

  // ---------------- t = ref * r ----------------
  dword_t pb_q [4][4];
  dword_t hb_q [4][2];
  dword_t t_q  [4];

  always_ff @(posedge clk_i) begin
    if (rdy[12]) begin
      for (int i = 0; i < 4; i++) begin
        for (int j = 0; j < 4; j++) pb_q[i][j] <= g4_q[i] * r11_q[j];
      end
    end
    if (rdy[13]) begin
      hb_q[0][0] <= pb_q[3][0] + pb_q[0][3];
      hb_q[0][1] <= pb_q[1][2] - pb_q[2][1];
      hb_q[1][0] <= pb_q[3][1] - pb_q[0][2];
      hb_q[1][1] <= pb_q[1][3] + pb_q[2][0];
      hb_q[2][0] <= pb_q[3][2] + pb_q[0][1];
      hb_q[2][1] <= pb_q[2][3] - pb_q[1][0];
      hb_q[3][0] <= pb_q[3][3] - pb_q[0][0];
      hb_q[3][1] <= -(pb_q[1][1] + pb_q[2][2]);
    end
    if (rdy[14]) begin
      for (int i = 0; i < 4; i++) t_q[i] <= hb_q[i][0] + hb_q[i][1];
    end
  end

  // ---------------- block scale t, squared norm ----------------
  logic [5:0]  rst_q;
  logic [4:0]  lst_q;
  dword_t      t15_q [4];
  word_t       t16_q [4], t17_q [4];
  dword_t      sq_q [4];
  logic [63:0] u_q  [2];

  always_ff @(posedge clk_i) begin
    if (rdy[15]) begin
      t15_q <= t_q;
      rst_q <= rs4(t_q[0], t_q[1], t_q[2], t_q[3]);
    end
    if (rdy[16]) begin
      for (int i = 0; i < 4; i++) t16_q[i] <= 32'(t15_q[i] >>> rst_q);
    end
    if (rdy[17]) begin
      t17_q <= t16_q;
      lst_q <= ls4(t16_q[0], t16_q[1], t16_q[2], t16_q[3]);
    end
    if (rdy[18]) begin
      for (int i = 0; i < 4; i++) t18_q[i] <= t17_q[i] <<< lst_q;
    end
    if (rdy[ST_SQR]) begin
      for (int i = 0; i < 4; i++) sq_q[i] <= t18_q[i] * t18_q[i];
    end
    if (rdy[20]) begin
      u_q[0] <= $unsigned(sq_q[0] + sq_q[1]);
      u_q[1] <= $unsigned(sq_q[2] + sq_q[3]);
    end
    if (rdy[ST_N2]) n2_q <= u_q[0] + u_q[1];
  end

  // ---------------- square root, one result bit per stage ----------------
  logic [63:0] srn_q [SQ_STEPS];
  logic [63:0] srr_q [SQ_STEPS];
  logic [63:0] srn_d [SQ_STEPS];
  logic [63:0] srr_d [SQ_STEPS];
  logic        szr_q [SQ_STEPS];
  logic [31:0] sroot;

  always_comb begin
    {srn_d[0], srr_d[0]} = sqrt_step(n2_q, 64'd0, 0);
    for (int k = 1; k < SQ_STEPS; k++) begin
      {srn_d[k], srr_d[k]} = sqrt_step(srn_q[k-1], srr_q[k-1], k);
    end
  end

  always_ff @(posedge clk_i) begin
    for (int k = 0; k < SQ_STEPS; k++) begin
      if (rdy[ST_SQ + k]) begin
        srn_q[k] <= srn_d[k];
        srr_q[k] <= srr_d[k];
        szr_q[k] <= (k == 0) ? (n2_q == 64'd0) : szr_q[(k == 0) ? 0 : k - 1];
      end
    end
  end

  assign sroot = srr_q[SQ_STEPS-1][31:0];

  // ---------------- rounded division, one quotient bit per stage ----------------
  logic [63:0] num_q [4];
  logic [31:0] den_q;
  logic        nzr_q;
  logic [63:0] dvr_q [DIV_STEPS][4];
  logic [F:0]  dvq_q [DIV_STEPS][4];
  logic [31:0] dvd_q [DIV_STEPS];
  logic        dvz_q [DIV_STEPS];
  logic [63:0] dvr_d [DIV_STEPS][4];
  logic [F:0]  dvq_d [DIV_STEPS][4];
  logic [31:0] dvd_d [DIV_STEPS];
  logic        dvz_d [DIV_STEPS];

  always_ff @(posedge clk_i) begin
    if (rdy[ST_NUM]) begin
      for (int i = 0; i < 4; i++) begin
        num_q[i] <= (64'(side_q[ST_NUM-1].mag[i]) << F) + 64'(sroot >> 1);
      end
      den_q <= sroot;
      nzr_q <= szr_q[SQ_STEPS-1];
    end
  end

  always_comb begin
    logic [64:0] st;
    for (int j = 0; j < DIV_STEPS; j++) begin
      dvd_d[j] = (j == 0) ? den_q : dvd_q[(j == 0) ? 0 : j - 1];
      dvz_d[j] = (j == 0) ? nzr_q : dvz_q[(j == 0) ? 0 : j - 1];
      for (int i = 0; i < 4; i++) begin
        if (j == 0) begin
          st          = div_step(num_q[i], den_q, F);
          dvq_d[j][i] = '0;
        end else begin
          st          = div_step(dvr_q[j-1][i], dvd_q[j-1], F - j);
          dvq_d[j][i] = dvq_q[j-1][i];
        end
        dvr_d[j][i]        = st[63:0];
        dvq_d[j][i][F - j] = st[64];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    for (int j = 0; j < DIV_STEPS; j++) begin
      if (rdy[ST_DIV + j]) begin
        dvr_q[j] <= dvr_d[j];
        dvq_q[j] <= dvq_d[j];
        dvd_q[j] <= dvd_d[j];
        dvz_q[j] <= dvz_d[j];
      end
    end
  end

  // ---------------- output register ----------------
  word_t oq_q [4];
  logic  ozero;

  assign ozero = dvz_q[DIV_STEPS-1];

  always_ff @(posedge clk_i) begin
    if (rdy[ST_OUT]) begin
      for (int i = 0; i < 4; i++) begin
        if (ozero) begin
          oq_q[i] <= (i == 3) ? QONE : '0;
        end else if (side_q[ST_OUT-1].neg[i]) begin
          oq_q[i] <= -word_t'(32'(dvq_q[DIV_STEPS-1][i]));
        end else begin
          oq_q[i] <= word_t'(32'(dvq_q[DIV_STEPS-1][i]));
        end
      end
    end
  end

  assign out_valid_o  = v_q[ST_OUT];
  assign out_pos_x_o  = side_q[ST_OUT].pos[0];
  assign out_pos_y_o  = side_q[ST_OUT].pos[1];
  assign out_pos_z_o  = side_q[ST_OUT].pos[2];
  assign out_quat_x_o = oq_q[0];
  assign out_quat_y_o = oq_q[1];
  assign out_quat_z_o = oq_q[2];
  assign out_quat_w_o = oq_q[3];

  // ---------------- assertions ----------------
  a_anchor_sticky: assert property (@(posedge clk_i) disable iff (!rst_ni)
    anchor_valid_q |=> anchor_valid_q)
    else $error("anchor flag cleared while running");

  a_anchor_dropped: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_acc && !anchor_valid_q) |=> !v_q[0])
    else $error("anchor request entered the pipeline");

  a_unit_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (out_quat_w_o <= QONE && out_quat_w_o >= -QONE &&
                     out_quat_x_o <= QONE && out_quat_x_o >= -QONE))
    else $error("normalized component out of unit range");

endmodule
